>>> src/rvc_pkg.sv
// rvc_pkg: shared types, opcodes and status codes of the rv32i core step block
// no dependencies, compiled first
package rvc_pkg;

  localparam int XLEN = 32;
  localparam int REG_IDX_W = 5;
  localparam int PADDR_W = 3;

  localparam logic [XLEN-1:0] RESET_START = 32'h0001_0000;

  // item kinds on the request channel
  localparam logic KIND_INSN = 1'b0;
  localparam logic KIND_LOAD_DATA = 1'b1;

  // major opcodes, instruction bits 6:2
  localparam logic [4:0] MAJ_LOAD = 5'h00;
  localparam logic [4:0] MAJ_OP_IMM = 5'h04;
  localparam logic [4:0] MAJ_AUIPC = 5'h05;
  localparam logic [4:0] MAJ_STORE = 5'h08;
  localparam logic [4:0] MAJ_OP = 5'h0C;
  localparam logic [4:0] MAJ_LUI = 5'h0D;
  localparam logic [4:0] MAJ_BRANCH = 5'h18;
  localparam logic [4:0] MAJ_JALR = 5'h19;
  localparam logic [4:0] MAJ_JAL = 5'h1B;

  localparam logic [6:0] F7_ALT = 7'h20;

  // result status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  // access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  // register byte addresses, bit 2 selects the register slot
  localparam logic [PADDR_W-1:0] ADDR_START = 3'd0;

  typedef struct packed {
    logic                 waiting;
    logic [REG_IDX_W-1:0] dest;
    logic [1:0]           size;
    logic                 zext;
  } ld_state_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      value;
  } rf_write_t;

  typedef struct packed {
    logic [XLEN-1:0]      next_pc;
    logic                 reg_write;
    logic [REG_IDX_W-1:0] reg_index;
    logic [XLEN-1:0]      reg_value;
    logic                 mem_rd;
    logic                 mem_write;
    logic [XLEN-1:0]      mem_address;
    logic [1:0]           mem_size;
    logic [XLEN-1:0]      store_data;
    logic [1:0]           status;
  } result_t;

endpackage

>>> src/rvc_in_if.sv
// rvc_in_if: request channel, instruction words and returned load data
// depends on nothing
interface rvc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] instruction;
  logic [31:0] load_data;

  modport source (output valid, output opcode, output instruction, output load_data,
                  input ready);
  modport sink (input valid, input opcode, input instruction, input load_data,
                output ready);
endinterface

>>> src/rvc_out_if.sv
// rvc_out_if: result channel, one result per request
// depends on nothing
interface rvc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_write;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        mem_rd;
  logic        mem_write;
  logic [31:0] mem_address;
  logic [1:0]  mem_size;
  logic [31:0] store_data;
  logic [1:0]  status;

  modport source (output valid, output next_pc, output reg_write, output reg_index,
                  output reg_value, output mem_rd, output mem_write,
                  output mem_address, output mem_size, output store_data,
                  output status, input ready);
  modport sink (input valid, input next_pc, input reg_write, input reg_index,
                input reg_value, input mem_rd, input mem_write, input mem_address,
                input mem_size, input store_data, input status, output ready);
endinterface

>>> src/rv32i_integer_core_step.sv
// rv32i_integer_core_step: rv32i base integer core, one request per item
// latency: two register stages (operand read, execute); an accepted request waits in the operand
// stage until the result register is free or drained, and its result is then registered there
// throughput: one request per cycle, held back only by a stalled result register
// reset: synchronous, clears pc to 0x10000, load tracking, and all of x1..x31
// (per-entry valid bits, no clearing pass); start_address resets to 0x10000
module rv32i_integer_core_step (
  input  logic                             clk,
  input  logic                             rst,
  rvc_in_if.sink                           item,
  rvc_out_if.source                        result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rvc_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rvc_pkg::*;

  // configuration: start_address is only stored and read back, pc resets to RESET_START; reset restores it
  logic [XLEN-1:0] start_address;
  logic            cfg_sel;

  assign pready = 1'b1;
  assign cfg_sel = (paddr[2] == ADDR_START[2]);
  assign prdata = cfg_sel ? start_address : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= RESET_START;
    end else if (psel && penable && pwrite && cfg_sel) begin
      start_address <= pwdata;
    end
  end

  // architectural state
  logic [XLEN-1:0] pc;
  ld_state_t       ld;

  // operand stage: request held here while register operands are read
  logic            s1_valid;
  logic            s1_kind;
  logic [XLEN-1:0] s1_insn;
  logic [XLEN-1:0] s1_ldata;
  logic [XLEN-1:0] rs1_data, rs2_data;

  // result register
  logic            out_valid;
  result_t         out_res;

  // execute results
  result_t         res_next;
  rf_write_t       rf_wr;
  rf_write_t       rf_commit;
  ld_state_t       ld_next;
  logic [XLEN-1:0] pc_next;

  logic            s1_adv;
  logic            take;

  // the operand stage moves on whenever the result register is free or drained
  assign s1_adv = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign take = item.valid && item.ready;

  // register write only lands when the item leaves the operand stage
  always_comb begin
    rf_commit = rf_wr;
    rf_commit.en = rf_wr.en && s1_adv;
  end

  // operand read happens on acceptance; the write of the item in execute
  // is forwarded so back to back dependent instructions see it
  rvc_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (take),
    .ra1      (item.instruction[19:15]),
    .ra2      (item.instruction[24:20]),
    .wr       (rf_commit),
    .rs1_data (rs1_data),
    .rs2_data (rs2_data)
  );

  rvc_exec u_exec (
    .kind    (s1_kind),
    .insn    (s1_insn),
    .ldata   (s1_ldata),
    .pc      (pc),
    .a       (rs1_data),
    .b       (rs2_data),
    .ld      (ld),
    .res     (res_next),
    .wr      (rf_wr),
    .ld_next (ld_next),
    .pc_next (pc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind <= item.opcode;
      s1_insn <= item.instruction;
      s1_ldata <= item.load_data;
    end
  end

  // state commits when the item leaves the operand stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= RESET_START;
      ld <= '0;
    end else if (s1_adv) begin
      pc <= pc_next;
      ld <= ld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= res_next;
    end
  end

  assign result.valid = out_valid;
  assign result.next_pc = out_res.next_pc;
  assign result.reg_write = out_res.reg_write;
  assign result.reg_index = out_res.reg_index;
  assign result.reg_value = out_res.reg_value;
  assign result.mem_rd = out_res.mem_rd;
  assign result.mem_write = out_res.mem_write;
  assign result.mem_address = out_res.mem_address;
  assign result.mem_size = out_res.mem_size;
  assign result.store_data = out_res.store_data;
  assign result.status = out_res.status;

  // a flagged result never writes a register or asks for memory
  a_flag_no_effect: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status != ST_OK) |->
      (!out_res.reg_write && !out_res.mem_rd && !out_res.mem_write))
    else $error("flagged result carries side effects");

  // a read request leaves the core waiting for load data
  a_load_waits: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && res_next.mem_rd) |=> ld.waiting)
    else $error("read request did not arm load wait");

  // the pc only moves when an item commits
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(pc))
    else $error("pc changed without a commit");

  // x0 is never written
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rf_commit.en |-> (rf_commit.idx != '0))
    else $error("register write aimed at x0");

endmodule

>>> src/rvc_regfile.sv
// rvc_regfile: x1..x31 with two registered read ports, one write port
// depends on rvc_pkg; x0 and unwritten entries read zero via valid bits
module rvc_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [rvc_pkg::REG_IDX_W-1:0] ra1,
  input  logic [rvc_pkg::REG_IDX_W-1:0] ra2,
  input  rvc_pkg::rf_write_t            wr,
  output logic [rvc_pkg::XLEN-1:0]      rs1_data,
  output logic [rvc_pkg::XLEN-1:0]      rs2_data
);
  import rvc_pkg::*;

  localparam int DEPTH = 1 << REG_IDX_W;

  logic [XLEN-1:0]  mem [DEPTH];
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.idx] <= 1'b1;
    end
  end

  // write data bypasses into the read registers in the same cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.value;
    end
    if (rd_en) begin
      rs1_data <= (wr.en && wr.idx == ra1) ? wr.value :
                  (written[ra1] ? mem[ra1] : '0);
      rs2_data <= (wr.en && wr.idx == ra2) ? wr.value :
                  (written[ra2] ? mem[ra2] : '0);
    end
  end

endmodule

>>> src/rvc_exec.sv
// rvc_exec: decode, alu, branch and load extension for one item
// depends on rvc_pkg; purely combinational
module rvc_exec (
  input  logic                     kind,
  input  logic [rvc_pkg::XLEN-1:0] insn,
  input  logic [rvc_pkg::XLEN-1:0] ldata,
  input  logic [rvc_pkg::XLEN-1:0] pc,
  input  logic [rvc_pkg::XLEN-1:0] a,
  input  logic [rvc_pkg::XLEN-1:0] b,
  input  rvc_pkg::ld_state_t       ld,
  output rvc_pkg::result_t         res,
  output rvc_pkg::rf_write_t       wr,
  output rvc_pkg::ld_state_t       ld_next,
  output logic [rvc_pkg::XLEN-1:0] pc_next
);
  import rvc_pkg::*;

  logic [4:0]      major;
  logic [4:0]      rd;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [XLEN-1:0] op2, alu_out, addr_sum, pc_plus4;
  logic            is_sub, lt_s, lt_u, br_lt_s, br_lt_u;

  assign major = insn[6:2];
  assign rd = insn[11:7];
  assign f3 = insn[14:12];
  assign f7 = insn[31:25];
  assign imm_i = {{20{insn[31]}}, insn[31:20]};
  assign imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
  assign imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
  assign imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
  assign imm_u = {insn[31:12], 12'b0};

  assign op2 = (major == MAJ_OP) ? b : imm_i;
  assign is_sub = (major == MAJ_OP) && f7[5];
  assign lt_s = $signed(a) < $signed(op2);
  assign lt_u = a < op2;
  assign br_lt_s = $signed(a) < $signed(b);
  assign br_lt_u = a < b;
  assign addr_sum = a + ((major == MAJ_STORE) ? imm_s : imm_i);
  assign pc_plus4 = pc + 32'd4;

  always_comb begin
    case (f3)
      3'd0: alu_out = is_sub ? a - op2 : a + op2;
      3'd1: alu_out = a << op2[4:0];
      3'd2: alu_out = {31'b0, lt_s};
      3'd3: alu_out = {31'b0, lt_u};
      3'd4: alu_out = a ^ op2;
      3'd5: alu_out = f7[5] ? XLEN'($signed(a) >>> op2[4:0]) : a >> op2[4:0];
      3'd6: alu_out = a | op2;
      default: alu_out = a & op2;
    endcase
  end

  always_comb begin
    logic [XLEN-1:0]      npc, wval, ext;
    logic [REG_IDX_W-1:0] widx;
    logic                 wreq, ill, taken;
    npc = pc_plus4;
    wval = '0;
    widx = rd;
    wreq = 1'b0;
    ill = 1'b0;
    taken = 1'b0;
    res = '0;
    ld_next = ld;
    case (ld.size)
      SZ_BYTE: ext = ld.zext ? {24'b0, ldata[7:0]} : {{24{ldata[7]}}, ldata[7:0]};
      SZ_HALF: ext = ld.zext ? {16'b0, ldata[15:0]} : {{16{ldata[15]}}, ldata[15:0]};
      default: ext = ldata;
    endcase

    if (kind == KIND_LOAD_DATA) begin
      if (!ld.waiting) begin
        res.status = ST_ORDER;
        npc = pc;
      end else begin
        // pc already moved past the load
        npc = pc;
        ld_next.waiting = 1'b0;
        wreq = 1'b1;
        widx = ld.dest;
        wval = ext;
      end
    end else if (ld.waiting) begin
      res.status = ST_ORDER;
      npc = pc;
    end else if (insn[1:0] != 2'b11) begin
      ill = 1'b1;
    end else begin
      case (major)
        MAJ_LUI: begin
          wreq = 1'b1;
          wval = imm_u;
        end
        MAJ_AUIPC: begin
          wreq = 1'b1;
          wval = pc + imm_u;
        end
        MAJ_OP_IMM: begin
          ill = (f3 == 3'd1 && f7 != 7'd0) ||
                (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT);
          wreq = 1'b1;
          wval = alu_out;
        end
        MAJ_OP: begin
          ill = !(f7 == 7'd0 || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)));
          wreq = 1'b1;
          wval = alu_out;
        end
        MAJ_LOAD: begin
          ill = (f3 == 3'd3) || (f3[2:1] == 2'b11);
          ld_next.waiting = 1'b1;
          ld_next.dest = rd;
          ld_next.size = f3[1:0];
          ld_next.zext = f3[2];
          res.mem_rd = 1'b1;
          res.mem_address = addr_sum;
          res.mem_size = f3[1:0];
        end
        MAJ_STORE: begin
          ill = (f3 > 3'd2);
          res.mem_write = 1'b1;
          res.mem_address = addr_sum;
          res.mem_size = f3[1:0];
          res.store_data = b;
        end
        MAJ_BRANCH: begin
          case (f3)
            3'd0: taken = (a == b);
            3'd1: taken = (a != b);
            3'd4: taken = br_lt_s;
            3'd5: taken = !br_lt_s;
            3'd6: taken = br_lt_u;
            3'd7: taken = !br_lt_u;
            default: ill = 1'b1;
          endcase
          if (taken) begin
            npc = pc + imm_b;
          end
        end
        MAJ_JALR: begin
          ill = (f3 != 3'd0);
          npc = {addr_sum[XLEN-1:1], 1'b0};
          wreq = 1'b1;
          wval = pc_plus4;
        end
        MAJ_JAL: begin
          npc = pc + imm_j;
          wreq = 1'b1;
          wval = pc_plus4;
        end
        default: ill = 1'b1;
      endcase
    end

    // unsupported encodings leave all state alone
    if (ill) begin
      res = '0;
      res.status = ST_ILLEGAL;
      npc = pc;
      wreq = 1'b0;
      ld_next = ld;
    end

    wr.en = wreq && (widx != '0);
    wr.idx = widx;
    wr.value = wval;
    res.reg_write = wr.en;
    res.reg_index = wr.en ? widx : '0;
    res.reg_value = wr.en ? wval : '0;
    res.next_pc = npc;
    pc_next = npc;
  end

endmodule
